// ----- design/family_lineage_tracker_top_defines.svh -----
// Assertion helpers for the lineage tracker top.
`ifndef FAMILY_LINEAGE_TRACKER_TOP_DEFINES_SVH
`define FAMILY_LINEAGE_TRACKER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FLT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define FLT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ----- design/flt_pkg.sv -----
package flt_pkg;

  localparam int MAX_POP = 256;
  localparam int IDX_W = $clog2(MAX_POP);
  localparam int SIZE_W = IDX_W + 1;
  localparam int POP_W = 9;
  localparam int CNT_W = 32;

  localparam logic [POP_W-1:0] POP_MIN = POP_W'(2);
  localparam logic [POP_W-1:0] POP_MAX = POP_W'(MAX_POP);
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  typedef enum logic [0:0] {
    FUNC_EVENT   = 1'b0,
    FUNC_RESTART = 1'b1
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] dying_index;
    logic [7:0] replicating_index;
  } event_t;

  typedef struct packed {
    logic [8:0]  extant_families;
    logic        fixed;
    logic [31:0] events_taken;
    logic        index_error;
  } result_t;

  // Write of one member's family.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] data;
  } map_wr_t;

  // Write of the growth count at the replicating family and the loss count
  // at the dying family.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  loss_fam;
    logic [IDX_W-1:0]  repl_fam;
    logic [SIZE_W-1:0] inc_data;
    logic [SIZE_W-1:0] dec_data;
  } size_wr_t;

endpackage

// ----- design/flt_member_map.sv -----
module flt_member_map
  import flt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             clear,
  input  logic [IDX_W-1:0] rd_addr_a,
  input  logic [IDX_W-1:0] rd_addr_b,
  input  map_wr_t          wr,
  output logic [IDX_W-1:0] rd_data_a,
  output logic [IDX_W-1:0] rd_data_b
);

  logic [IDX_W-1:0] mem [MAX_POP];
  logic [MAX_POP-1:0] valid;

  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [IDX_W-1:0] raw_a;
  logic [IDX_W-1:0] raw_b;
  logic             valid_a;
  logic             valid_b;

  logic             prev_clear;
  logic             prev_we;
  logic [IDX_W-1:0] prev_addr;
  logic [IDX_W-1:0] prev_data;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.we) begin
        mem[wr.addr] <= wr.data;
      end
      raw_a     <= mem[rd_addr_a];
      raw_b     <= mem[rd_addr_b];
      addr_a    <= rd_addr_a;
      addr_b    <= rd_addr_b;
      prev_addr <= wr.addr;
      prev_data <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      valid_a    <= 1'b0;
      valid_b    <= 1'b0;
      prev_clear <= 1'b0;
      prev_we    <= 1'b0;
    end else if (en) begin
      valid_a    <= valid[rd_addr_a];
      valid_b    <= valid[rd_addr_b];
      prev_clear <= clear;
      prev_we    <= wr.we;
      if (clear) begin
        valid <= '0;
      end else if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  // The registered read misses the write made in the same cycle, so that
  // write is replayed here. An entry never written since restart is its own
  // family.
  always_comb begin
    if (prev_clear) begin
      rd_data_a = addr_a;
    end else if (prev_we && (prev_addr == addr_a)) begin
      rd_data_a = prev_data;
    end else if (valid_a) begin
      rd_data_a = raw_a;
    end else begin
      rd_data_a = addr_a;
    end
  end

  always_comb begin
    if (prev_clear) begin
      rd_data_b = addr_b;
    end else if (prev_we && (prev_addr == addr_b)) begin
      rd_data_b = prev_data;
    end else if (valid_b) begin
      rd_data_b = raw_b;
    end else begin
      rd_data_b = addr_b;
    end
  end

endmodule

// ----- design/flt_size_table.sv -----
module flt_size_table
  import flt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              clear,
  input  logic [IDX_W-1:0]  rd_loss_fam,
  input  logic [IDX_W-1:0]  rd_repl_fam,
  input  size_wr_t          wr,
  output logic [SIZE_W-1:0] size_dying,
  output logic [SIZE_W-1:0] inc_repl,
  output logic [SIZE_W-1:0] dec_dying
);

  // A family's size is kept as one plus members gained minus members lost,
  // so that each event writes each table at one address only.
  logic [SIZE_W-1:0] inc_mem [MAX_POP];
  logic [SIZE_W-1:0] dec_mem [MAX_POP];
  logic [MAX_POP-1:0] inc_valid;
  logic [MAX_POP-1:0] dec_valid;

  logic [IDX_W-1:0]  dfam;
  logic [IDX_W-1:0]  rfam;
  logic [SIZE_W-1:0] raw_inc_d;
  logic [SIZE_W-1:0] raw_inc_r;
  logic [SIZE_W-1:0] raw_dec_d;
  logic              vld_inc_d;
  logic              vld_inc_r;
  logic              vld_dec_d;

  logic              prev_clear;
  logic              prev_we;
  logic [IDX_W-1:0]  prev_dfam;
  logic [IDX_W-1:0]  prev_rfam;
  logic [SIZE_W-1:0] prev_inc;
  logic [SIZE_W-1:0] prev_dec;

  logic [SIZE_W-1:0] inc_dying;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.we) begin
        inc_mem[wr.repl_fam] <= wr.inc_data;
        dec_mem[wr.loss_fam] <= wr.dec_data;
      end
      raw_inc_d <= inc_mem[rd_loss_fam];
      raw_inc_r <= inc_mem[rd_repl_fam];
      raw_dec_d <= dec_mem[rd_loss_fam];
      dfam      <= rd_loss_fam;
      rfam      <= rd_repl_fam;
      prev_dfam <= wr.loss_fam;
      prev_rfam <= wr.repl_fam;
      prev_inc  <= wr.inc_data;
      prev_dec  <= wr.dec_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_valid  <= '0;
      dec_valid  <= '0;
      vld_inc_d  <= 1'b0;
      vld_inc_r  <= 1'b0;
      vld_dec_d  <= 1'b0;
      prev_clear <= 1'b0;
      prev_we    <= 1'b0;
    end else if (en) begin
      vld_inc_d  <= inc_valid[rd_loss_fam];
      vld_inc_r  <= inc_valid[rd_repl_fam];
      vld_dec_d  <= dec_valid[rd_loss_fam];
      prev_clear <= clear;
      prev_we    <= wr.we;
      if (clear) begin
        inc_valid <= '0;
        dec_valid <= '0;
      end else if (wr.we) begin
        inc_valid[wr.repl_fam] <= 1'b1;
        dec_valid[wr.loss_fam] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (prev_clear) begin
      inc_dying = '0;
    end else if (prev_we && (prev_rfam == dfam)) begin
      inc_dying = prev_inc;
    end else if (vld_inc_d) begin
      inc_dying = raw_inc_d;
    end else begin
      inc_dying = '0;
    end
  end

  always_comb begin
    if (prev_clear) begin
      inc_repl = '0;
    end else if (prev_we && (prev_rfam == rfam)) begin
      inc_repl = prev_inc;
    end else if (vld_inc_r) begin
      inc_repl = raw_inc_r;
    end else begin
      inc_repl = '0;
    end
  end

  always_comb begin
    if (prev_clear) begin
      dec_dying = '0;
    end else if (prev_we && (prev_dfam == dfam)) begin
      dec_dying = prev_dec;
    end else if (vld_dec_d) begin
      dec_dying = raw_dec_d;
    end else begin
      dec_dying = '0;
    end
  end

  assign size_dying = SIZE_W'(1) + inc_dying - dec_dying;

endmodule

// ----- design/family_lineage_tracker_top.sv -----
// Throughput: one transaction per cycle; a stalled result holds the whole pipeline,
// which runs input register, member map read, size table read, result register.
// Reset (rst, synchronous, active high) clears the pipeline, sets population
// to 256 and returns every member to a family of its own at once; there is no
// clearing pass, and a restart transaction returns every member likewise.
`include "family_lineage_tracker_top_defines.svh"

module family_lineage_tracker_top
  import flt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [POP_W-1:0] cfg_data,
  input  logic             event_valid,
  output logic             event_stall,
  input  event_t           event_item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result_item
);

  logic [POP_W-1:0] population;
  logic [POP_W-1:0] eff_pop;

  logic             en;
  logic             s1_valid;
  event_t           s1_item;
  logic             s2_valid;
  event_t           s2_item;
  logic             s3_valid;
  event_t           s3_item;
  logic [IDX_W-1:0] s3_df;
  logic [IDX_W-1:0] s3_rf;

  logic [POP_W-1:0] living;
  logic [POP_W-1:0] living_next;
  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] counter_next;
  result_t          result_next;

  logic [IDX_W-1:0] map_rd_d;
  logic [IDX_W-1:0] map_rd_r;
  logic [IDX_W-1:0] df2;
  logic [IDX_W-1:0] rf2;

  logic [SIZE_W-1:0] size_dying;
  logic [SIZE_W-1:0] inc_repl;
  logic [SIZE_W-1:0] dec_dying;

  logic s3_restart;
  logic s3_event;
  logic s3_err;
  logic s3_apply;
  logic s3_move;
  logic s3_grow;
  logic s3_extinct;

  map_wr_t  map_wr;
  size_wr_t size_wr;

  assign en          = !(result_valid && result_stall);
  assign event_stall = !en;

  always_comb begin
    if (population < POP_MIN) begin
      eff_pop = POP_MIN;
    end else if (population > POP_MAX) begin
      eff_pop = POP_MAX;
    end else begin
      eff_pop = population;
    end
  end

  flt_member_map u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .clear     (s3_restart),
    .rd_addr_a (s1_item.dying_index),
    .rd_addr_b (s1_item.replicating_index),
    .wr        (map_wr),
    .rd_data_a (map_rd_d),
    .rd_data_b (map_rd_r)
  );

  // The map output covers writes up to last cycle; the transaction now in
  // the last stage may still restart or move a member that is read here.
  always_comb begin
    if (s3_restart) begin
      df2 = s2_item.dying_index;
      rf2 = s2_item.replicating_index;
    end else begin
      df2 = (map_wr.we && (map_wr.addr == s2_item.dying_index)) ? map_wr.data : map_rd_d;
      rf2 = (map_wr.we && (map_wr.addr == s2_item.replicating_index)) ?
            map_wr.data : map_rd_r;
    end
  end

  flt_size_table u_sizes (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .clear       (s3_restart),
    .rd_loss_fam (df2),
    .rd_repl_fam (rf2),
    .wr          (size_wr),
    .size_dying  (size_dying),
    .inc_repl    (inc_repl),
    .dec_dying   (dec_dying)
  );

  assign s3_restart = s3_valid && (s3_item.func == FUNC_RESTART);
  assign s3_event   = s3_valid && (s3_item.func == FUNC_EVENT);
  assign s3_err     = s3_event && (({1'b0, s3_item.dying_index} >= eff_pop) ||
                                   ({1'b0, s3_item.replicating_index} >= eff_pop));
  assign s3_apply   = s3_event && !s3_err && (living > POP_W'(1));
  assign s3_move    = s3_apply && (s3_item.dying_index != s3_item.replicating_index);
  assign s3_grow    = s3_move && (s3_df != s3_rf);
  assign s3_extinct = s3_grow && (size_dying == SIZE_W'(1));

  always_comb begin
    map_wr.we   = s3_move;
    map_wr.addr = s3_item.dying_index;
    map_wr.data = s3_rf;

    size_wr.we       = s3_grow;
    size_wr.loss_fam = s3_df;
    size_wr.repl_fam = s3_rf;
    size_wr.inc_data = inc_repl + SIZE_W'(1);
    size_wr.dec_data = dec_dying + SIZE_W'(1);
  end

  always_comb begin
    if (s3_restart) begin
      living_next = eff_pop;
    end else if (s3_extinct) begin
      living_next = living - POP_W'(1);
    end else begin
      living_next = living;
    end

    if (s3_restart) begin
      counter_next = '0;
    end else if (s3_apply && (counter != CNT_SAT)) begin
      counter_next = counter + CNT_W'(1);
    end else begin
      counter_next = counter;
    end

    result_next.extant_families = living_next;
    result_next.fixed           = (living_next <= POP_W'(1));
    result_next.events_taken    = counter_next;
    result_next.index_error     = s3_err;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item     <= event_item;
      s2_item     <= s1_item;
      s3_item     <= s2_item;
      s3_df       <= df2;
      s3_rf       <= rf2;
      result_item <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      population   <= POP_MAX;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
      living       <= POP_MAX;
      counter      <= '0;
    end else begin
      if (cfg_we) begin
        population <= cfg_data;
      end
      if (en) begin
        s1_valid     <= event_valid;
        s2_valid     <= s1_valid;
        s3_valid     <= s2_valid;
        result_valid <= s3_valid;
        if (s3_valid) begin
          living  <= living_next;
          counter <= counter_next;
        end
      end
    end
  end

  `FLT_ASSERT(a_living_range, (living != '0) && (living <= POP_MAX), "living count out of range")
  `FLT_ASSERT(a_dying_family_nonempty, !size_wr.we || (size_dying != '0), "empty family shrank")
  `FLT_ASSERT_NEXT(a_restart_clears, en && s3_restart,
                   (counter == '0) && (living == $past(eff_pop)),
                   "restart did not reset counters")
  `FLT_ASSERT_NEXT(a_fixation_frozen, en && s3_event && (living <= POP_W'(1)),
                   $stable(living) && $stable(counter),
                   "state changed after fixation")

endmodule
